[design/lsps_pkg.sv]
// Package for the line sensor PID steering block: field widths, register
// reset values, register indexes, sequencer states and the line error table.
// No dependencies.
package lsps_pkg;

    localparam int SENSOR_W  = 5;
    localparam int IN_DATA_W = 8;
    localparam int GAIN_W    = 12;
    localparam int SPEED_W   = 12;
    localparam int LIMIT_W   = 8;
    localparam int ERR_W     = 3;
    localparam int DERIV_W   = 4;
    localparam int SUM_W     = 24;
    localparam int PD_W      = 16;
    localparam int PROD_W    = SUM_W + 1 + GAIN_W;
    localparam int CORR_W    = PROD_W + 1;
    localparam int RAW_W     = CORR_W + 1;
    localparam int OUT_DATA_W = 32;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DATA_W = 12;

    localparam logic [GAIN_W-1:0]  GAIN_P_RST     = 12'd160;
    localparam logic [GAIN_W-1:0]  GAIN_I_RST     = 12'd0;
    localparam logic [GAIN_W-1:0]  GAIN_D_RST     = 12'd96;
    localparam logic [SPEED_W-1:0] CRUISE_SPD_RST = 12'd480;
    localparam logic [SPEED_W-1:0] SPEED_MAX_RST  = 12'd1600;
    localparam logic [SPEED_W-1:0] SPEED_MIN_RST  = 12'd0;
    localparam logic [LIMIT_W-1:0] LOST_LIMIT_RST = 8'd24;
    localparam logic [LIMIT_W-1:0] DARK_MAX       = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P     = 8'd0,
        CFG_GAIN_I     = 8'd1,
        CFG_GAIN_D     = 8'd2,
        CFG_CRUISE_SPD = 8'd3,
        CFG_SPEED_MAX  = 8'd4,
        CFG_SPEED_MIN  = 8'd5,
        CFG_LOST_LIMIT = 8'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_DONE
    } t_state;

    // weighted centroid, weights -2..2 from bit 0 up, truncated toward zero
    localparam logic signed [ERR_W-1:0] ERR_TABLE [32] = '{
        3'sd0,  -3'sd2, -3'sd1, -3'sd1,  3'sd0, -3'sd1,  3'sd0, -3'sd1,
        3'sd1,   3'sd0,  3'sd0,  3'sd0,  3'sd0,  3'sd0,  3'sd0,  3'sd0,
        3'sd2,   3'sd0,  3'sd0,  3'sd0,  3'sd1,  3'sd0,  3'sd0,  3'sd0,
        3'sd1,   3'sd0,  3'sd0,  3'sd0,  3'sd1,  3'sd0,  3'sd0,  3'sd0
    };

endpackage

[design/lsps_serial_mul.sv]
// Shift-add multiplier: signed multiplicand times unsigned multiplier,
// one multiplier bit per cycle. Depends on lsps_pkg for default widths.
module lsps_serial_mul #(
    parameter int A_W = lsps_pkg::SUM_W,
    parameter int B_W = lsps_pkg::GAIN_W
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic signed [A_W-1:0]      i_a,
    input  logic        [B_W-1:0]      i_b,
    output logic                       o_done,
    output logic signed [A_W+B_W:0]    o_prod
);

    localparam int CNT_W = (B_W > 1) ? $clog2(B_W) : 1;

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic signed [A_W-1:0] r_a;
    logic [B_W-1:0]       r_b;
    logic signed [A_W:0]  r_hi;
    logic [B_W-1:0]       r_lo;
    logic signed [A_W:0]  w_t;

    // partial sum with one guard bit; hi never exceeds |a| after the shift
    assign w_t = r_hi + (r_b[0] ? {r_a[A_W-1], r_a} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(B_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a  <= i_a;
            r_b  <= i_b;
            r_hi <= '0;
            r_lo <= '0;
        end else if (r_busy) begin
            r_hi <= {w_t[A_W], w_t[A_W:1]};
            r_lo <= {w_t[0], r_lo[B_W-1:1]};
            r_b  <= r_b >> 1;
        end
    end

    assign o_done = r_done;
    assign o_prod = {r_hi, r_lo};

endmodule

[design/lsps_wheel_clamp.sv]
// Wheel drive: signed raw speed to reverse flag and clamped magnitude.
// Depends on lsps_pkg for widths.
module lsps_wheel_clamp (
    input  logic signed [lsps_pkg::RAW_W-1:0]   i_raw,
    input  logic        [lsps_pkg::SPEED_W-1:0] i_speed_max,
    input  logic        [lsps_pkg::SPEED_W-1:0] i_speed_min,
    output logic        [lsps_pkg::SPEED_W-1:0] o_speed,
    output logic                                o_reverse
);

    localparam int RAW_W = lsps_pkg::RAW_W;

    logic [RAW_W-1:0]             w_mag;
    logic [lsps_pkg::SPEED_W-1:0] w_lim;

    always_comb begin
        o_reverse = i_raw[RAW_W-1];
        w_mag     = o_reverse ? RAW_W'(-i_raw) : RAW_W'(i_raw);
        // limit to max first, then raise to min
        if (w_mag > RAW_W'(i_speed_max)) begin
            w_lim = i_speed_max;
        end else begin
            w_lim = w_mag[lsps_pkg::SPEED_W-1:0];
        end
        if (w_lim < i_speed_min) begin
            o_speed = i_speed_min;
        end else begin
            o_speed = w_lim;
        end
    end

endmodule

[design/line_sensor_pid_steering.sv]
// Top level of the line sensor PID steering block: config registers,
// PID state, sequencer and output register.
// Depends on lsps_pkg, lsps_serial_mul and lsps_wheel_clamp.
//
// Usage:
//  - Slave stream (s_tvalid/s_tready/s_tdata): one transfer per control
//    tick, s_tdata[4:0] = sensor bits. s_tready is high only while the
//    sequencer is idle.
//  - Master stream (m_tvalid/m_tready/m_tdata): one result per tick, held
//    in an output register until taken. The next tick is accepted while a
//    result still waits; if it finishes before the old one is taken, the
//    sequencer holds in its final state until the output register frees.
//  - Config channel (i_cfg_valid/o_cfg_ready/i_cfg_index/i_cfg_data):
//    always ready; index 0..6 = gain_p, gain_i, gain_d, cruise speed,
//    speed_max, speed_min, lost_limit. Other indexes are ignored.
//  - Sequence: the integral term gain_i*error_sum is formed by a shift-add
//    multiplier taking one gain_i bit per cycle (12 steps); then come the
//    correction add, the wheel add and the clamp/output load, in that order.
//    A new tick is taken only after the result of the last one is loaded
//    into the output register, when s_tready returns.
//  - Reset (synchronous, active low): registers to their defaults, PID
//    state and dark counter to zero, no result pending.
module line_sensor_pid_steering (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [lsps_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lsps_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // [4:0] sensor_bits, [7:5] unused
    input  logic [lsps_pkg::IN_DATA_W-1:0]  s_tdata,
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // [11:0] left wheel magnitude, [12] left_reverse, [24:13] right wheel
    // magnitude, [25] right_reverse, [28:26] line_error, [29] corner_seen,
    // [31:30] zero
    output logic [lsps_pkg::OUT_DATA_W-1:0] m_tdata
);

    localparam int SUM_W   = lsps_pkg::SUM_W;
    localparam int ERR_W   = lsps_pkg::ERR_W;
    localparam int DERIV_W = lsps_pkg::DERIV_W;
    localparam int PD_W    = lsps_pkg::PD_W;
    localparam int PROD_W  = lsps_pkg::PROD_W;
    localparam int CORR_W  = lsps_pkg::CORR_W;
    localparam int RAW_W   = lsps_pkg::RAW_W;
    localparam int SPEED_W = lsps_pkg::SPEED_W;

    localparam logic signed [SUM_W:0] SUM_HI = (SUM_W+1)'(2**(SUM_W-1) - 1);
    localparam logic signed [SUM_W:0] SUM_LO = -(SUM_W+1)'(2**(SUM_W-1));

    // config registers
    logic [lsps_pkg::GAIN_W-1:0]  r_gain_p, r_gain_i, r_gain_d;
    logic [SPEED_W-1:0]           r_cruise_spd, r_speed_max, r_speed_min;
    logic [lsps_pkg::LIMIT_W-1:0] r_lost_limit;

    // PID and corner state
    logic signed [SUM_W-1:0]      r_err_sum;
    logic signed [ERR_W-1:0]      r_prev_err;
    logic [lsps_pkg::LIMIT_W-1:0] r_dark_run;

    // per-tick working registers
    logic signed [ERR_W-1:0]  r_err;
    logic                     r_corner;
    logic signed [PD_W-1:0]   r_pd;
    logic signed [CORR_W-1:0] r_corr;
    logic signed [RAW_W-1:0]  r_left_raw, r_right_raw;

    lsps_pkg::t_state r_state, n_state;

    logic                        r_m_tvalid;
    logic [lsps_pkg::OUT_DATA_W-1:0] r_m_tdata;

    // accept-cycle logic
    logic                         w_accept;
    logic                         w_load;
    logic signed [ERR_W-1:0]      w_err;
    logic signed [DERIV_W-1:0]    w_deriv;
    logic signed [SUM_W:0]        w_sum_wide;
    logic signed [SUM_W-1:0]      w_sum;
    logic [lsps_pkg::LIMIT_W-1:0] w_dark;
    logic signed [PD_W-1:0]       w_pterm, w_dterm;

    logic                         w_mul_done;
    logic signed [PROD_W-1:0]     w_prod;

    logic [SPEED_W-1:0] w_left_mag, w_right_mag;
    logic               w_left_rev, w_right_rev;

    assign o_cfg_ready = 1'b1;
    assign s_tready    = (r_state == lsps_pkg::ST_IDLE);
    assign w_accept    = s_tvalid && s_tready;

    assign w_err   = lsps_pkg::ERR_TABLE[s_tdata[lsps_pkg::SENSOR_W-1:0]];
    assign w_deriv = DERIV_W'(w_err) - DERIV_W'(r_prev_err);

    // integral saturates at the 24-bit signed limits
    always_comb begin
        w_sum_wide = (SUM_W+1)'(r_err_sum) + (SUM_W+1)'(w_err);
        if (w_sum_wide > SUM_HI) begin
            w_sum = SUM_HI[SUM_W-1:0];
        end else if (w_sum_wide < SUM_LO) begin
            w_sum = SUM_LO[SUM_W-1:0];
        end else begin
            w_sum = w_sum_wide[SUM_W-1:0];
        end
    end

    // dark run counter, saturating, cleared by any lit sensor
    always_comb begin
        if (s_tdata[lsps_pkg::SENSOR_W-1:0] != '0) begin
            w_dark = '0;
        end else if (r_dark_run != lsps_pkg::DARK_MAX) begin
            w_dark = r_dark_run + 1'b1;
        end else begin
            w_dark = r_dark_run;
        end
    end

    // small P and D products: 12-bit gain times 3- or 4-bit signed value
    assign w_pterm = PD_W'($signed({1'b0, r_gain_p})) * PD_W'(w_err);
    assign w_dterm = PD_W'($signed({1'b0, r_gain_d})) * PD_W'(w_deriv);

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p     <= lsps_pkg::GAIN_P_RST;
            r_gain_i     <= lsps_pkg::GAIN_I_RST;
            r_gain_d     <= lsps_pkg::GAIN_D_RST;
            r_cruise_spd <= lsps_pkg::CRUISE_SPD_RST;
            r_speed_max  <= lsps_pkg::SPEED_MAX_RST;
            r_speed_min  <= lsps_pkg::SPEED_MIN_RST;
            r_lost_limit <= lsps_pkg::LOST_LIMIT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                lsps_pkg::CFG_GAIN_P:     r_gain_p     <= i_cfg_data;
                lsps_pkg::CFG_GAIN_I:     r_gain_i     <= i_cfg_data;
                lsps_pkg::CFG_GAIN_D:     r_gain_d     <= i_cfg_data;
                lsps_pkg::CFG_CRUISE_SPD: r_cruise_spd <= i_cfg_data;
                lsps_pkg::CFG_SPEED_MAX:  r_speed_max  <= i_cfg_data;
                lsps_pkg::CFG_SPEED_MIN:  r_speed_min  <= i_cfg_data;
                lsps_pkg::CFG_LOST_LIMIT: r_lost_limit <= i_cfg_data[lsps_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // PID state updates on every accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err_sum  <= '0;
            r_prev_err <= '0;
            r_dark_run <= '0;
        end else if (w_accept) begin
            r_err_sum  <= w_sum;
            r_prev_err <= w_err;
            r_dark_run <= w_dark;
        end
    end

    // working registers along the sequence
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_err    <= w_err;
            r_corner <= (w_dark >= r_lost_limit);
            r_pd     <= w_pterm + w_dterm;
        end
        if (r_state == lsps_pkg::ST_MUL && w_mul_done) begin
            r_corr <= CORR_W'(w_prod) + CORR_W'(r_pd);
        end
        if (r_state == lsps_pkg::ST_ADD) begin
            r_left_raw  <= RAW_W'(r_cruise_spd) + RAW_W'(r_corr);
            r_right_raw <= RAW_W'(r_cruise_spd) - RAW_W'(r_corr);
        end
    end

    lsps_serial_mul #(
        .A_W (lsps_pkg::SUM_W),
        .B_W (lsps_pkg::GAIN_W)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_a     (w_sum),
        .i_b     (r_gain_i),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    lsps_wheel_clamp u_left (
        .i_raw       (r_left_raw),
        .i_speed_max (r_speed_max),
        .i_speed_min (r_speed_min),
        .o_speed     (w_left_mag),
        .o_reverse   (w_left_rev)
    );

    lsps_wheel_clamp u_right (
        .i_raw       (r_right_raw),
        .i_speed_max (r_speed_max),
        .i_speed_min (r_speed_min),
        .o_speed     (w_right_mag),
        .o_reverse   (w_right_rev)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lsps_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        w_load  = 1'b0;
        unique case (r_state)
            lsps_pkg::ST_IDLE: begin
                if (w_accept) n_state = lsps_pkg::ST_MUL;
            end
            lsps_pkg::ST_MUL: begin
                if (w_mul_done) n_state = lsps_pkg::ST_ADD;
            end
            lsps_pkg::ST_ADD: begin
                n_state = lsps_pkg::ST_DONE;
            end
            lsps_pkg::ST_DONE: begin
                // wait here while an older result is still stalled
                if (!r_m_tvalid || m_tready) begin
                    w_load  = 1'b1;
                    n_state = lsps_pkg::ST_IDLE;
                end
            end
            default: n_state = lsps_pkg::ST_IDLE;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (w_load) begin
            r_m_tvalid <= 1'b1;
        end else if (m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_m_tdata <= {2'b00, r_corner, r_err, w_right_rev, w_right_mag,
                          w_left_rev, w_left_mag};
        end
    end

    assign m_tvalid = r_m_tvalid;
    assign m_tdata  = r_m_tdata;

endmodule

[tb/testbench.sv]
// Self-checking bench for line_sensor_pid_steering: sensor ticks in, wheel commands out,
// each result compared with a local model of the PID steering.
// Depends on lsps_pkg and the line_sensor_pid_steering RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // indexes outside the register map, written to show they are ignored
    localparam logic [lsps_pkg::CFG_IDX_W-1:0] CFG_IDX_FIRST_FREE = 8'd7;
    localparam logic [lsps_pkg::CFG_IDX_W-1:0] CFG_IDX_LAST       = 8'd255;

    localparam int     N_REGS       = 7;
    localparam int     PHASE_TICKS  = 200;
    localparam int     LONG_DARK    = 300;   // past the 255 saturation of the dark counter
    localparam int     SETTLE_TICKS = 32;    // idle clocks before the final leftover check
    localparam longint ACC_HI       = 64'sd8388607;
    localparam longint ACC_LO       = -64'sd8388608;

    // m_tdata layout, MSB first
    typedef struct packed {
        logic [1:0]                        pad;
        logic                              corner;
        logic signed [lsps_pkg::ERR_W-1:0] line_err;
        logic                              rrev;
        logic [lsps_pkg::SPEED_W-1:0]      rspd;
        logic                              lrev;
        logic [lsps_pkg::SPEED_W-1:0]      lspd;
    } t_steer_cmd;

    typedef logic [lsps_pkg::CFG_DATA_W-1:0] t_reg_set [N_REGS];

    localparam lsps_pkg::t_cfg_idx REG_ORDER [N_REGS] = '{
        lsps_pkg::CFG_GAIN_P, lsps_pkg::CFG_GAIN_I, lsps_pkg::CFG_GAIN_D,
        lsps_pkg::CFG_CRUISE_SPD, lsps_pkg::CFG_SPEED_MAX, lsps_pkg::CFG_SPEED_MIN,
        lsps_pkg::CFG_LOST_LIMIT
    };

    // one line pixel at a time, both edges, pairs, wide and split lines
    localparam logic [lsps_pkg::SENSOR_W-1:0] TICKS_DEFAULTS [20] = '{
        5'h00, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F, 5'h03, 5'h18, 5'h11,
        5'h07, 5'h1C, 5'h06, 5'h0C, 5'h0B, 5'h19, 5'h1A, 5'h1E, 5'h15, 5'h0E
    };
    // with base 20 and kp 1.25*8: hard left/right give a wheel of exactly zero,
    // then a dark stretch that crosses a lost limit of 2
    localparam logic [lsps_pkg::SENSOR_W-1:0] TICKS_ZERO_SPEED [6] = '{
        5'h01, 5'h10, 5'h00, 5'h00, 5'h00, 5'h04
    };

    logic                             i_clk       = 1'b0;
    logic                             i_rst_n     = 1'b0;
    logic                             i_cfg_valid = 1'b0;
    logic                             o_cfg_ready;
    logic [lsps_pkg::CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [lsps_pkg::CFG_DATA_W-1:0]  i_cfg_data  = '0;
    logic                             s_tvalid    = 1'b0;
    logic                             s_tready;
    logic [lsps_pkg::IN_DATA_W-1:0]   s_tdata     = '0;
    logic                             m_tvalid;
    logic                             m_tready    = 1'b0;
    logic [lsps_pkg::OUT_DATA_W-1:0]  m_tdata;

    logic [lsps_pkg::SENSOR_W-1:0] pending_ticks [$];
    t_steer_cmd                    expected_cmds [$];
    int                            errors        = 0;
    int                            send_idle_pct = 20;
    int                            recv_idle_pct = 80;

    // model copy of the register file
    logic [lsps_pkg::GAIN_W-1:0]   kp       = lsps_pkg::GAIN_P_RST;
    logic [lsps_pkg::GAIN_W-1:0]   ki       = lsps_pkg::GAIN_I_RST;
    logic [lsps_pkg::GAIN_W-1:0]   kd       = lsps_pkg::GAIN_D_RST;
    logic [lsps_pkg::SPEED_W-1:0]  base_spd = lsps_pkg::CRUISE_SPD_RST;
    logic [lsps_pkg::SPEED_W-1:0]  spd_max  = lsps_pkg::SPEED_MAX_RST;
    logic [lsps_pkg::SPEED_W-1:0]  spd_min  = lsps_pkg::SPEED_MIN_RST;
    logic [lsps_pkg::LIMIT_W-1:0]  lost_lim = lsps_pkg::LOST_LIMIT_RST;
    // model copy of the PID state
    logic signed [lsps_pkg::SUM_W-1:0] err_acc  = '0;
    logic signed [lsps_pkg::ERR_W-1:0] last_err = '0;
    logic [lsps_pkg::LIMIT_W-1:0]      dark_cnt = '0;

    line_sensor_pid_steering dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always #6 i_clk = ~i_clk;

    function automatic void apply_reg_write(logic [lsps_pkg::CFG_IDX_W-1:0] idx,
                                            logic [lsps_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            lsps_pkg::CFG_GAIN_P:     kp       = data;
            lsps_pkg::CFG_GAIN_I:     ki       = data;
            lsps_pkg::CFG_GAIN_D:     kd       = data;
            lsps_pkg::CFG_CRUISE_SPD: base_spd = data;
            lsps_pkg::CFG_SPEED_MAX:  spd_max  = data;
            lsps_pkg::CFG_SPEED_MIN:  spd_min  = data;
            lsps_pkg::CFG_LOST_LIMIT: lost_lim = data[lsps_pkg::LIMIT_W-1:0];
            default: ;
        endcase
    endfunction

    // sign/magnitude split, then clamp to max first and min last
    function automatic void clamp_wheel(input longint raw,
                                        output logic [lsps_pkg::SPEED_W-1:0] spd,
                                        output logic rev);
        longint mag;
        rev = (raw < 0);
        mag = rev ? -raw : raw;
        if (mag > longint'(spd_max)) mag = longint'(spd_max);
        if (mag < longint'(spd_min)) mag = longint'(spd_min);
        spd = mag[lsps_pkg::SPEED_W-1:0];
    endfunction

    // one control tick: line error, corner counter, PID update, wheel split
    function automatic t_steer_cmd steer_predict(logic [lsps_pkg::SENSOR_W-1:0] bits);
        t_steer_cmd                        cmd;
        int                                weight_sum;
        int                                lit;
        int                                deriv;
        logic signed [lsps_pkg::ERR_W-1:0] err;
        longint                            acc;
        longint                            corr;
        weight_sum = 0;
        lit = 0;
        for (int i = 0; i < lsps_pkg::SENSOR_W; i++) begin
            if (bits[i]) begin
                weight_sum += i - 2;
                lit++;
            end
        end
        // int division truncates toward zero
        err = (lit != 0) ? lsps_pkg::ERR_W'(weight_sum / lit) : '0;

        if (bits == '0) begin
            if (dark_cnt != lsps_pkg::DARK_MAX) dark_cnt++;
        end else begin
            dark_cnt = '0;
        end

        acc = longint'(err_acc) + longint'(err);
        if (acc > ACC_HI) acc = ACC_HI;
        if (acc < ACC_LO) acc = ACC_LO;
        err_acc = lsps_pkg::SUM_W'(acc);

        deriv = int'(err) - int'(last_err);
        last_err = err;

        corr = longint'(kp) * longint'(err) + longint'(ki) * longint'(err_acc)
             + longint'(kd) * longint'(deriv);

        clamp_wheel(longint'(base_spd) + corr, cmd.lspd, cmd.lrev);
        clamp_wheel(longint'(base_spd) - corr, cmd.rspd, cmd.rrev);
        cmd.line_err = err;
        cmd.corner   = (dark_cnt >= lost_lim);
        cmd.pad      = '0;
        return cmd;
    endfunction

    function automatic void check_field(string what, longint want, longint got);
        if (want != got) begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        end
    endfunction

    // Input driver: one tick per transfer, prediction taken at the transfer edge.
    // s_tvalid is only dropped or reloaded once the current item is gone.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                expected_cmds.push_back(steer_predict(s_tdata[lsps_pkg::SENSOR_W-1:0]));
            if (!s_tvalid || s_tready) begin
                if (pending_ticks.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= lsps_pkg::IN_DATA_W'(pending_ticks.pop_front());
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: random backpressure, every transfer checked against the
    // oldest prediction
    always @(posedge i_clk) begin : monitor
        t_steer_cmd got;
        t_steer_cmd want;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (expected_cmds.size() == 0) begin
                    errors++;
                    $display("%0t ns: unexpected result, expected none, actual %h",
                             $time, m_tdata);
                end else begin
                    want = expected_cmds.pop_front();
                    check_field("left_mag",      want.lspd,     got.lspd);
                    check_field("left_reverse",  want.lrev,     got.lrev);
                    check_field("right_mag",     want.rspd,     got.rspd);
                    check_field("right_reverse", want.rrev,     got.rrev);
                    check_field("line_error",    want.line_err, got.line_err);
                    check_field("corner_seen",   want.corner,   got.corner);
                    check_field("padding",       want.pad,      got.pad);
                end
            end
            m_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    // keeps i_cfg_valid high from one write to the next; caller lowers it
    task automatic write_reg(logic [lsps_pkg::CFG_IDX_W-1:0] idx,
                             logic [lsps_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_reg_write(idx, data);
    endtask

    task automatic load_settings(t_reg_set vals);
        for (int i = 0; i < N_REGS; i++)
            write_reg(REG_ORDER[i], vals[i]);
        write_reg(CFG_IDX_FIRST_FREE, lsps_pkg::CFG_DATA_W'($urandom()));
        write_reg(CFG_IDX_LAST, lsps_pkg::CFG_DATA_W'($urandom()));
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // sender stops until the block has handed back everything it took
    task automatic drain_results();
        do @(posedge i_clk);
        while (pending_ticks.size() != 0 || s_tvalid || expected_cmds.size() != 0);
    endtask

    // mostly a line drifting under the array, plus noise and dark stretches
    task automatic queue_random_ticks(int count, bit long_dark);
        int                            queued;
        int                            pos;
        int                            len;
        int                            pick;
        logic [lsps_pkg::SENSOR_W-1:0] pat;
        queued = 0;
        pos = $urandom_range(8, 0);
        if (long_dark) begin
            repeat (LONG_DARK) pending_ticks.push_back('0);
            queued += LONG_DARK;
        end
        while (queued < count) begin
            pick = $urandom_range(99, 0);
            if (pick < 60) begin
                len = $urandom_range(20, 4);
                repeat (len) begin
                    case ($urandom_range(2, 0))
                        0: if (pos > 0) pos--;
                        2: if (pos < 8) pos++;
                        default: ;
                    endcase
                    // even position: one sensor; odd: the two it straddles
                    pat = (pos % 2 == 0) ? 5'b00001 << (pos / 2) : 5'b00011 << (pos / 2);
                    if ($urandom_range(7, 0) == 0) pat = pat | (pat << 1);
                    pending_ticks.push_back(pat);
                    queued++;
                end
            end else if (pick < 80) begin
                pending_ticks.push_back(lsps_pkg::SENSOR_W'($urandom()));
                queued++;
            end else begin
                len = $urandom_range(30, 1);
                repeat (len) pending_ticks.push_back('0);
                queued += len;
            end
        end
    endtask

    initial begin
        t_reg_set rnd;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed ticks on the reset register values
        foreach (TICKS_DEFAULTS[i]) pending_ticks.push_back(TICKS_DEFAULTS[i]);
        drain_results();
        load_settings('{12'd10, 12'd0, 12'd0, 12'd20, 12'd1600, 12'd0, 12'd2});
        foreach (TICKS_ZERO_SPEED[i]) pending_ticks.push_back(TICKS_ZERO_SPEED[i]);
        drain_results();

        // modest gains, upper data bits above the lost limit width dropped
        load_settings('{12'd24, 12'd1, 12'd40, 12'd480, 12'd1600, 12'd0, 12'hF05});
        queue_random_ticks(PHASE_TICKS, 1'b0);
        drain_results();

        // every register but speed_min at full scale; long dark run saturates the counter
        load_settings('{12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'd0, 12'd255});
        queue_random_ticks(PHASE_TICKS + LONG_DARK, 1'b1);
        drain_results();

        send_idle_pct = 80;
        recv_idle_pct = 20;
        // min above max pins both wheels; lost limit masks to zero
        load_settings('{12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'hFFF, 12'h100});
        queue_random_ticks(PHASE_TICKS, 1'b0);
        drain_results();

        foreach (rnd[i]) rnd[i] = lsps_pkg::CFG_DATA_W'($urandom());
        load_settings(rnd);
        queue_random_ticks(PHASE_TICKS, 1'b0);
        drain_results();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        // integral-heavy steering, narrow clamp window, corner on first dark tick
        load_settings('{12'd16, 12'hFFF, 12'd0, 12'd2048, 12'd3000, 12'd200, 12'd1});
        queue_random_ticks(PHASE_TICKS, 1'b0);
        drain_results();

        repeat (SETTLE_TICKS) @(posedge i_clk);
        if (expected_cmds.size() != 0) begin
            errors++;
            $display("%0t ns: leftover results, expected 0, actual %0d",
                     $time, expected_cmds.size());
        end
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #6_000_000;
        $display("%0t ns: timeout", $time);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
